[rtl/swr_pkg.sv]
package swr_pkg;

   // Default sizes of the slot store.
   localparam int MAX_WINDOW_DEF = 32;
   localparam int TAG_WIDTH_DEF  = 16;

   // Fixed field widths of the channels.
   localparam int SEQ_W      = 32;
   localparam int TAG_PORT_W = 16;
   localparam int CONN_W     = 16;
   localparam int WIN_W      = 6;
   localparam int TYPE_W     = 3;

   localparam logic [WIN_W-1:0] WIN_RESET = 6'd8;

   // Packet type codes.
   localparam logic [TYPE_W-1:0] PKT_START = 3'd0;
   localparam logic [TYPE_W-1:0] PKT_END   = 3'd1;
   localparam logic [TYPE_W-1:0] PKT_DATA  = 3'd2;

   // Result kinds.
   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   typedef enum logic [1:0] {
      PH_WAIT_START,
      PH_WAIT_DATA,
      PH_RECEIVE
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_READ,
      ST_ACK
   } ctl_state_type;

endpackage

[rtl/swr_if.sv]
interface swr_req_if;
   import swr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    checksum_ok;
   logic [TYPE_W-1:0]       pkt_type;
   logic [SEQ_W-1:0]        seq_num;
   logic [TAG_PORT_W-1:0]   payload_tag;

   modport source (output valid, checksum_ok, pkt_type, seq_num, payload_tag, input ready);
   modport sink   (input valid, checksum_ok, pkt_type, seq_num, payload_tag, output ready);
endinterface

interface swr_rsp_if;
   import swr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [SEQ_W-1:0]        seq_value;
   logic [TAG_PORT_W-1:0]   deliver_tag;
   logic [CONN_W-1:0]       connection;
   logic                    last;

   modport source (output valid, kind, seq_value, deliver_tag, connection, last, input ready);
   modport sink   (input valid, kind, seq_value, deliver_tag, connection, last, output ready);
endinterface

interface swr_csr_if;
   import swr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [WIN_W-1:0]        win_wdata;

   modport source (output valid, win_wdata, input ready);
   modport sink   (input valid, win_wdata, output ready);
endinterface

[rtl/swr_ram.sv]
module swr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/sliding_window_receiver.sv]
// Sequencing: each item is taken in ST_IDLE and classified in ST_DECODE, which writes a
// start or end ack to the output register; data inside the window then passes ST_CHECK,
// and ST_READ once for each parked chunk released, before ST_ACK gives its ack, and data
// outside the window goes straight to ST_ACK. A new item is taken only back in ST_IDLE,
// and any state that emits waits until the output register is free. The release loop
// reads each chunk's tag through the tag RAM's registered read.
// Reset is synchronous: phase, counters and slot-full bits clear, the window goes to 8,
// and the tag RAM keeps its contents, since no tag is read before its full bit is set.
module sliding_window_receiver #(
   parameter int MAX_WINDOW = swr_pkg::MAX_WINDOW_DEF,
   parameter int TAG_WIDTH  = swr_pkg::TAG_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   swr_req_if.sink   req_chan,
   swr_rsp_if.source rsp_chan,
   swr_csr_if.sink   csr_chan
);
   import swr_pkg::*;

   // Width of a slot index and of the release counter, which must hold MAX_WINDOW itself.
   localparam int HW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW = $clog2(MAX_WINDOW + 1);
   // Head plus offset stays below twice the largest window, so seven bits suffice.
   localparam int SUM_W = WIN_W + 1;

   // Sequencer and protocol state.
   ctl_state_type          state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [SEQ_W-1:0]       expected_ff, expected_in;
   logic [SEQ_W-1:0]       start_seq_ff, start_seq_in;
   logic [CONN_W-1:0]      conn_ff, conn_in;
   logic [HW-1:0]          head_ff, head_in;
   logic [MAX_WINDOW-1:0]  full_ff, full_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [WIN_W-1:0]       win_ff;

   // The item under work, captured when it is taken.
   logic                   item_ok_ff;
   logic [TYPE_W-1:0]      item_type_ff;
   logic [SEQ_W-1:0]       item_seq_ff;
   logic [TAG_WIDTH-1:0]   item_tag_ff;

   // Output register; it holds a result while the consumer stalls, and the sequencer waits only when it is full.
   logic                   rsp_valid_ff;
   logic                   rsp_kind_ff;
   logic [SEQ_W-1:0]       rsp_seq_ff;
   logic [TAG_PORT_W-1:0]  rsp_tag_ff;
   logic [CONN_W-1:0]      rsp_conn_ff;
   logic                   rsp_last_ff;

   logic                   emit;
   logic                   emit_kind;
   logic [SEQ_W-1:0]       emit_seq;
   logic [TAG_PORT_W-1:0]  emit_tag;
   logic                   emit_last;
   logic                   out_free;
   logic                   req_fire;

   // Decode of the captured item.
   logic                   ack_item;
   logic [SEQ_W-1:0]       ack_item_seq;
   logic                   data_item;
   logic [WIN_W-1:0]       win_eff;
   logic [SEQ_W-1:0]       offset;
   logic                   in_win;
   logic                   direct;
   logic [SUM_W-1:0]       slot_sum;
   logic [SUM_W-1:0]       slot_wrap;
   logic [HW-1:0]          slot_idx;
   logic [HW-1:0]          head_next;
   logic                   head_full;
   logic                   cnt_room;

   // Tag width conversions between the ports and the store.
   logic [TAG_WIDTH+TAG_PORT_W-1:0] in_tag_wide;
   logic [TAG_PORT_W+TAG_WIDTH-1:0] item_tag_wide;
   logic [TAG_PORT_W+TAG_WIDTH-1:0] ram_tag_wide;

   // Tag RAM signals.
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [TAG_WIDTH-1:0]   ram_rd_data;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign in_tag_wide   = {{TAG_WIDTH{1'b0}}, req_chan.payload_tag};
   assign item_tag_wide = {{TAG_PORT_W{1'b0}}, item_tag_ff};
   assign ram_tag_wide  = {{TAG_PORT_W{1'b0}}, ram_rd_data};

   // Classify the captured item against the current phase. Only start, end and data
   // matter; every other code, and any packet that failed its checksum, is dropped.
   always_comb begin
      ack_item = 1'b0;
      unique case (phase_ff)
         PH_WAIT_START: begin
            ack_item = (item_type_ff == PKT_START) || (item_type_ff == PKT_END);
         end
         PH_WAIT_DATA: begin
            ack_item = (item_type_ff == PKT_START);
         end
         PH_RECEIVE: begin
            ack_item = (item_type_ff == PKT_END);
         end
         default: begin
            ack_item = 1'b0;
         end
      endcase
      ack_item  = ack_item && item_ok_ff;
      data_item = item_ok_ff && (item_type_ff == PKT_DATA) && (phase_ff != PH_WAIT_START);
      // A repeated start while waiting for data is answered with the stored start number.
      ack_item_seq = (phase_ff == PH_WAIT_DATA) ? start_seq_ff : item_seq_ff;
   end

   // Window test. The offset wraps, so numbers behind the expected one look far ahead
   // and fall outside the window as duplicates.
   always_comb begin
      win_eff   = (win_ff > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_ff;
      offset    = item_seq_ff - expected_ff;
      in_win    = offset < {{(SEQ_W-WIN_W){1'b0}}, win_eff};
      direct    = in_win && (offset == '0);
      slot_sum  = SUM_W'(head_ff) + SUM_W'(offset[WIN_W-1:0]);
      slot_wrap = (slot_sum >= SUM_W'(MAX_WINDOW)) ? (slot_sum - SUM_W'(MAX_WINDOW))
                                                   : slot_sum;
      slot_idx  = slot_wrap[HW-1:0];
      head_next = (head_ff == HW'(MAX_WINDOW - 1)) ? '0 : (head_ff + 1'b1);
      head_full = full_ff[head_ff];
      cnt_room  = cnt_ff < CW'(MAX_WINDOW);
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (ack_item) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (data_item) begin
               if (direct) begin
                  if (out_free) begin
                     state_in = ST_CHECK;
                  end
               end else if (in_win) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_ACK;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            // Release continues while the head slot holds a parked chunk and the count is below MAX_WINDOW.
            if (head_full && cnt_room) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_READ: begin
            if (out_free) begin
               state_in = ST_CHECK;
            end
         end
         ST_ACK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Results, state updates and RAM accesses for each sequencer state.
   always_comb begin
      phase_in     = phase_ff;
      expected_in  = expected_ff;
      start_seq_in = start_seq_ff;
      conn_in      = conn_ff;
      head_in      = head_ff;
      full_in      = full_ff;
      cnt_in       = cnt_ff;
      emit         = 1'b0;
      emit_kind    = KIND_ACK;
      emit_seq     = expected_ff;
      emit_tag     = '0;
      emit_last    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      unique case (state_ff)
         ST_DECODE: begin
            if (ack_item) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_kind = KIND_ACK;
                  emit_seq  = ack_item_seq;
                  emit_last = 1'b1;
                  if ((phase_ff == PH_WAIT_START) && (item_type_ff == PKT_START)) begin
                     // A new connection starts with an empty window.
                     start_seq_in = item_seq_ff;
                     expected_in  = '0;
                     head_in      = '0;
                     full_in      = '0;
                     phase_in     = PH_WAIT_DATA;
                  end else if (phase_ff == PH_RECEIVE) begin
                     // End of a connection: the ack carries the old index.
                     conn_in  = conn_ff + 1'b1;
                     phase_in = PH_WAIT_START;
                  end
               end
            end else if (data_item) begin
               phase_in = PH_RECEIVE;
               cnt_in   = '0;
               if (direct) begin
                  if (out_free) begin
                     emit              = 1'b1;
                     emit_kind         = KIND_DELIVER;
                     emit_seq          = item_seq_ff;
                     emit_tag          = item_tag_wide[TAG_PORT_W-1:0];
                     full_in[head_ff]  = 1'b0;
                     expected_in       = expected_ff + 1'b1;
                     head_in           = head_next;
                     cnt_in            = CW'(1);
                  end
               end else if (in_win) begin
                  // Park the chunk; a slot already full is simply overwritten.
                  ram_wr_en         = 1'b1;
                  full_in[slot_idx] = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            ram_rd_en = 1'b1;
         end
         ST_READ: begin
            if (out_free) begin
               emit             = 1'b1;
               emit_kind        = KIND_DELIVER;
               emit_seq         = expected_ff;
               emit_tag         = ram_tag_wide[TAG_PORT_W-1:0];
               full_in[head_ff] = 1'b0;
               expected_in      = expected_ff + 1'b1;
               head_in          = head_next;
               cnt_in           = cnt_ff + 1'b1;
            end
         end
         ST_ACK: begin
            // Cumulative ack of the expected number closes every data item.
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = KIND_ACK;
               emit_seq  = expected_ff;
               emit_last = 1'b1;
            end
         end
         ST_IDLE: begin
            emit = 1'b0;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_WAIT_START;
         expected_ff  <= '0;
         start_seq_ff <= '0;
         conn_ff      <= '0;
         head_ff      <= '0;
         full_ff      <= '0;
         cnt_ff       <= '0;
         win_ff       <= WIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         expected_ff  <= expected_in;
         start_seq_ff <= start_seq_in;
         conn_ff      <= conn_in;
         head_ff      <= head_in;
         full_ff      <= full_in;
         cnt_ff       <= cnt_in;
         if (csr_chan.valid) begin
            win_ff <= csr_chan.win_wdata;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ok_ff   <= req_chan.checksum_ok;
         item_type_ff <= req_chan.pkt_type;
         item_seq_ff  <= req_chan.seq_num;
         item_tag_ff  <= in_tag_wide[TAG_WIDTH-1:0];
      end
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_seq_ff  <= emit_seq;
         rsp_tag_ff  <= emit_tag;
         rsp_conn_ff <= conn_ff;
         rsp_last_ff <= emit_last;
      end
   end

   // Parked payload handles, one entry per window slot.
   swr_ram #(
      .WIDTH (TAG_WIDTH),
      .DEPTH (MAX_WINDOW)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_idx),
      .wr_data (item_tag_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = rsp_kind_ff;
   assign rsp_chan.seq_value   = rsp_seq_ff;
   assign rsp_chan.deliver_tag = rsp_tag_ff;
   assign rsp_chan.connection  = rsp_conn_ff;
   assign rsp_chan.last        = rsp_last_ff;
endmodule

[tb/sliding_window_receiver_tb.sv]
`timescale 1ns / 100ps

// Self-checking bench for the selective-repeat receiver. Packet headers go in
// on the request channel, and a tracker in this module keeps its own copy of
// the receiver state. For each accepted header it queues the deliveries and
// the acknowledgement that the block owes. Every result taken from the
// response channel is checked field by field against the oldest owed result.
module sliding_window_receiver_tb;
   import swr_pkg::*;

   localparam int SLOTS         = MAX_WINDOW_DEF;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 400000;

   // Type codes that the receiver ignores. The package only names the ones it acts on.
   localparam logic [TYPE_W-1:0] PKT_ACK    = 3'd3;
   localparam logic [TYPE_W-1:0] PKT_ERROR  = 3'd4;
   localparam logic [TYPE_W-1:0] PKT_UNUSED = 3'd7;

   typedef struct packed {
      logic                  kind;
      logic [SEQ_W-1:0]      seq_value;
      logic [TAG_PORT_W-1:0] deliver_tag;
      logic [CONN_W-1:0]     connection;
      logic                  last;
   } rsp_item_type;

   logic clock;
   logic reset;

   swr_req_if req_bus ();
   swr_rsp_if rsp_bus ();
   swr_csr_if csr_bus ();

   sliding_window_receiver u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // The tracker's copy of the receiver state.
   logic [WIN_W-1:0]      win_copy;
   phase_type             ph;
   logic [SEQ_W-1:0]      next_seq;
   logic [SEQ_W-1:0]      start_seq_copy;
   logic [CONN_W-1:0]     conn_copy;
   int                    head;
   logic                  slot_busy [SLOTS];
   logic [TAG_PORT_W-1:0] slot_payload [SLOTS];

   // Results that the block owes, oldest first.
   rsp_item_type due_results [$];
   rsp_item_type want_rsp;

   int send_idle_pct  = 0;
   int rcv_idle_pct   = 0;
   int hold_left      = 0;
   int fail_count     = 0;
   int answered_items = 0;
   int cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog. A hung handshake or a result that never comes ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Response side. A long hold, when one is requested, overrides the random
   // stalls so that the block backs up all the way to its input.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   function automatic void check_field(input string name, input logic [SEQ_W-1:0] want,
                                       input logic [SEQ_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   // Every accepted result is matched against the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         if (due_results.size() == 0) begin
            $error("result with nothing owed: kind %0d seq_value %h deliver_tag %h",
                   rsp_bus.kind, rsp_bus.seq_value, rsp_bus.deliver_tag);
            fail_count++;
         end else begin
            want_rsp = due_results[0];
            due_results.delete(0);
            check_field("kind", want_rsp.kind, rsp_bus.kind);
            check_field("seq_value", want_rsp.seq_value, rsp_bus.seq_value);
            check_field("deliver_tag", want_rsp.deliver_tag, rsp_bus.deliver_tag);
            check_field("connection", want_rsp.connection, rsp_bus.connection);
            check_field("last", want_rsp.last, rsp_bus.last);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tracker
   // ---------------------------------------------------------------------

   function automatic void clear_tracker();
      win_copy       = WIN_RESET;
      ph             = PH_WAIT_START;
      next_seq       = '0;
      start_seq_copy = '0;
      conn_copy      = '0;
      head           = 0;
      for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
   endfunction

   function automatic void owe(input logic kind, input logic [SEQ_W-1:0] seq_value,
                               input logic [TAG_PORT_W-1:0] tag);
      rsp_item_type r;
      r.kind        = kind;
      r.seq_value   = seq_value;
      r.deliver_tag = tag;
      r.connection  = conn_copy;
      r.last        = 1'b0;
      due_results.insert(due_results.size(), r);
   endfunction

   // Hand over the chunk at the head of the window and slide it by one.
   function automatic void step_window();
      slot_busy[head] = 1'b0;
      next_seq = next_seq + 1'b1;
      head = (head + 1) % SLOTS;
   endfunction

   // A data header: deliver or park it, release whatever became contiguous,
   // then acknowledge the cumulative number. The release stops after a full
   // window's worth of deliveries in one step.
   function automatic int take_data_item(input logic [SEQ_W-1:0] seq,
                                         input logic [TAG_PORT_W-1:0] tag);
      logic [SEQ_W-1:0] span;
      logic [SEQ_W-1:0] off;
      int n;
      int s;
      n = 0;
      span = (win_copy > SLOTS) ? SLOTS : win_copy;
      // Numbers behind the expected one wrap to huge offsets and fall outside.
      off = seq - next_seq;
      if (off < span) begin
         if (off == 0) begin
            owe(KIND_DELIVER, seq, tag);
            n++;
            step_window();
         end else begin
            // A second copy of a parked number simply replaces the tag.
            s = (head + int'(off)) % SLOTS;
            slot_busy[s] = 1'b1;
            slot_payload[s] = tag;
         end
         while (slot_busy[head] && n < SLOTS) begin
            owe(KIND_DELIVER, next_seq, slot_payload[head]);
            n++;
            step_window();
         end
      end
      owe(KIND_ACK, next_seq, '0);
      return n + 1;
   endfunction

   function automatic int track_header(input logic ok, input logic [TYPE_W-1:0] ptype,
                                       input logic [SEQ_W-1:0] seq,
                                       input logic [TAG_PORT_W-1:0] tag);
      int n;
      rsp_item_type r;
      n = 0;
      if (ok) begin
         case (ph)
            PH_WAIT_DATA: begin
               // A repeated start is answered with the number the first one carried.
               if (ptype == PKT_START) begin
                  owe(KIND_ACK, start_seq_copy, '0);
                  n = 1;
               end else if (ptype == PKT_DATA) begin
                  n = take_data_item(seq, tag);
                  ph = PH_RECEIVE;
               end
            end
            PH_RECEIVE: begin
               if (ptype == PKT_DATA) begin
                  n = take_data_item(seq, tag);
               end else if (ptype == PKT_END) begin
                  // The ack still carries the connection that is closing.
                  owe(KIND_ACK, seq, '0);
                  n = 1;
                  conn_copy = conn_copy + 1'b1;
                  ph = PH_WAIT_START;
               end
            end
            default: begin
               if (ptype == PKT_START) begin
                  start_seq_copy = seq;
                  next_seq = '0;
                  head = 0;
                  for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
                  owe(KIND_ACK, seq, '0);
                  n = 1;
                  ph = PH_WAIT_DATA;
               end else if (ptype == PKT_END) begin
                  // A late end of the previous connection is acked again.
                  owe(KIND_ACK, seq, '0);
                  n = 1;
               end
            end
         endcase
      end
      if (n > 0) begin
         r = due_results[due_results.size() - 1];
         r.last = 1'b1;
         due_results[due_results.size() - 1] = r;
      end
      return n;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   function automatic logic [TAG_PORT_W-1:0] rand_tag();
      return TAG_PORT_W'($urandom);
   endfunction

   // Offers one header, possibly after a few idle cycles, and waits for the
   // block to take it. Valid is left high: the next call or the settle task
   // sets it at the following falling edge.
   task automatic send_packet(input logic ok, input logic [TYPE_W-1:0] ptype,
                              input logic [SEQ_W-1:0] seq, input logic [TAG_PORT_W-1:0] tag);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.checksum_ok <= ok;
      req_bus.pkt_type    <= ptype;
      req_bus.seq_num     <= seq;
      req_bus.payload_tag <= tag;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (track_header(ok, ptype, seq, tag) > 0) answered_items++;
   endtask

   // Stops offering headers and waits until everything owed has come out,
   // then gives an ignored header time to leave the pipeline as well.
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(input logic [WIN_W-1:0] value);
      settle_block();
      @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.win_wdata <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      win_copy = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Bring the connection state back to waiting for start.
   task automatic close_connection();
      while (ph != PH_WAIT_START)
         send_packet(1'b1, (ph == PH_WAIT_DATA) ? PKT_DATA : PKT_END, $urandom, rand_tag());
   endtask

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------

   // Nothing but an end gets an answer before a start has been seen.
   task automatic test_idle_phase_items();
      send_packet(1'b1, PKT_END, 32'h1234_5678, 16'h5A5A);
      send_packet(1'b0, PKT_START, 32'hFFFF_FFFF, 16'hFFFF);
      send_packet(1'b1, PKT_ACK, 32'h0000_0001, 16'h0001);
      send_packet(1'b1, PKT_ERROR, 32'h8000_0000, 16'h8000);
      send_packet(1'b1, PKT_UNUSED, 32'h7FFF_FFFF, 16'h7FFF);
      send_packet(1'b1, PKT_DATA, 32'h0000_0000, 16'h0000);
   endtask

   // One whole connection at the reset window of eight: repeated start,
   // early end, out-of-order parking, duplicates, far numbers, a tag
   // overwritten in its slot, both edges of the window, and the end.
   task automatic test_connection_flow();
      send_packet(1'b1, PKT_START, 32'hFFFF_FFFF, 16'h0000);
      send_packet(1'b1, PKT_START, 32'h0000_0005, 16'h1111);
      send_packet(1'b1, PKT_END, 32'h0000_0009, 16'h2222);
      send_packet(1'b1, PKT_DATA, 32'd2, 16'h0001);
      send_packet(1'b1, PKT_DATA, 32'd0, 16'hFFFF);
      send_packet(1'b1, PKT_DATA, 32'd1, 16'h00FF);
      send_packet(1'b1, PKT_DATA, 32'd0, 16'h0F0F);
      send_packet(1'b1, PKT_DATA, 32'h8000_0000, 16'hF0F0);
      send_packet(1'b1, PKT_DATA, 32'd4, 16'hAAAA);
      send_packet(1'b1, PKT_DATA, 32'd4, 16'h5555);
      send_packet(1'b1, PKT_DATA, 32'd3, 16'h1234);
      send_packet(1'b1, PKT_DATA, 32'd12, 16'h4321);
      send_packet(1'b1, PKT_DATA, 32'd13, 16'h8765);
      send_packet(1'b1, PKT_START, 32'h0000_0100, 16'h0000);
      send_packet(1'b1, PKT_END, 32'h0000_0000, 16'h0000);
   endtask

   // A zero window accepts nothing, yet every data header is still acked.
   task automatic test_window_zero();
      set_window('0);
      send_packet(1'b1, PKT_START, 32'hA5A5_A5A5, 16'h0000);
      send_packet(1'b1, PKT_DATA, 32'd0, 16'hBEEF);
      send_packet(1'b1, PKT_END, 32'h5A5A_5A5A, 16'h0000);
   endtask

   // Full window sent in reverse while the response side is held off: the
   // block must fill up and stall its input, and the last header is delivered
   // and releases all thirty-one parked chunks at once.
   task automatic test_output_backpressure();
      set_window(6'd32);
      close_connection();
      hold_left = 400;
      send_packet(1'b1, PKT_START, $urandom, rand_tag());
      for (int j = SLOTS - 1; j >= 0; j--)
         send_packet(1'b1, PKT_DATA, j, rand_tag());
      send_packet(1'b1, PKT_END, $urandom, rand_tag());
   endtask

   // The sender goes quiet in the middle of a connection until every owed
   // result is out, then fills the gap.
   task automatic test_sender_pause();
      send_packet(1'b1, PKT_START, $urandom, rand_tag());
      send_packet(1'b1, PKT_DATA, 32'd2, rand_tag());
      send_packet(1'b1, PKT_DATA, 32'd1, rand_tag());
      settle_block();
      send_packet(1'b1, PKT_DATA, 32'd0, rand_tag());
      send_packet(1'b1, PKT_END, $urandom, rand_tag());
   endtask

   // ---------------------------------------------------------------------
   // Random traffic
   // ---------------------------------------------------------------------

   // Extremes come up often; anything from zero to the register's top can.
   function automatic logic [WIN_W-1:0] pick_window();
      case ($urandom_range(5))
         0: return 6'd1;
         1: return 6'd32;
         2: return 6'd63;
         3: return 6'd0;
         default: return WIN_W'($urandom_range(1, 63));
      endcase
   endfunction

   // Headers that should be dropped or that arrive in the wrong phase.
   task automatic send_noise();
      case ($urandom_range(2))
         0: send_packet(1'b0, TYPE_W'($urandom_range(7)), $urandom, rand_tag());
         1: send_packet(1'b1, TYPE_W'($urandom_range(3, 7)), $urandom, rand_tag());
         default: send_packet(1'b1, TYPE_W'($urandom_range(2)), $urandom, rand_tag());
      endcase
   endtask

   // A run of data numbers starting at the expected one, shuffled or sent in
   // reverse, with the odd duplicate or wild number mixed in. Lengths reach
   // a little past the window so that its far edge is exercised.
   task automatic send_data_burst();
      int span;
      int len;
      int shape;
      int k;
      int t;
      int offs [SLOTS + 2];
      logic [SEQ_W-1:0] base;
      span = (win_copy > SLOTS) ? SLOTS : win_copy;
      shape = $urandom_range(9);
      if (span == 0) len = $urandom_range(1, 3);
      else if (shape < 3) len = span;
      else len = $urandom_range(1, span + 2);
      for (int j = 0; j < len; j++) offs[j] = (shape < 2) ? len - 1 - j : j;
      if (shape >= 2) begin
         for (int j = len - 1; j > 0; j--) begin
            k = $urandom_range(j);
            t = offs[j];
            offs[j] = offs[k];
            offs[k] = t;
         end
      end
      base = next_seq;
      for (int j = 0; j < len; j++) begin
         case ($urandom_range(19))
            0: send_packet(1'b1, PKT_DATA, base - 1 - $urandom_range(3), rand_tag());
            1: send_packet(1'b1, PKT_DATA, $urandom, rand_tag());
            2: send_noise();
            default: ;
         endcase
         send_packet(1'b1, PKT_DATA, base + offs[j], rand_tag());
      end
   endtask

   // Mostly well-formed connections: start, bursts of data, end.
   task automatic random_step();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         send_noise();
      end else begin
         case (ph)
            PH_WAIT_START: begin
               if (roll < 85) send_packet(1'b1, PKT_START, $urandom, rand_tag());
               else send_packet(1'b1, PKT_END, $urandom, rand_tag());
            end
            PH_WAIT_DATA: begin
               if (roll < 14) send_packet(1'b1, PKT_START, $urandom, rand_tag());
               else if (roll < 18) send_packet(1'b1, PKT_END, $urandom, rand_tag());
               else send_data_burst();
            end
            default: begin
               if (roll < 16) send_packet(1'b1, PKT_END, $urandom, rand_tag());
               else send_data_burst();
            end
         endcase
      end
   endtask

   // Stretches of traffic, each under a freshly written window.
   task automatic random_phase(input int goal);
      int stop_at;
      int chunk_end;
      stop_at = answered_items + goal;
      while (answered_items < stop_at) begin
         set_window(pick_window());
         chunk_end = answered_items + $urandom_range(20, 45);
         while (answered_items < chunk_end && answered_items < stop_at)
            random_step();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.checksum_ok   = 1'b0;
      req_bus.pkt_type      = PKT_START;
      req_bus.seq_num       = '0;
      req_bus.payload_tag   = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.win_wdata     = '0;
      clear_tracker();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Sender mostly busy, receiver stalling most of the time.
      send_idle_pct = 6;
      rcv_idle_pct  = 73;
      test_idle_phase_items();
      test_connection_flow();
      test_window_zero();
      random_phase(100);

      // Sender sparse, receiver nearly always ready.
      send_idle_pct = 73;
      rcv_idle_pct  = 6;
      random_phase(100);

      // Full rate on both sides.
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      test_output_backpressure();
      test_sender_pause();
      random_phase(100);

      settle_block();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
